@@ design/kwsm_pkg.sv @@
package kwsm_pkg;

    typedef enum logic
    {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic
    {
        S_IDLE   = 1'b0,
        S_REFILL = 1'b1
    } state_t;

    typedef struct packed
    {
        func_t              func;
        logic [2:0]         list_index;
        logic signed [15:0] value;
    } item_t;

    typedef struct packed
    {
        status_t            status;
        logic signed [15:0] out_value;
        logic [2:0]         source_list;
    } result_t;

endpackage

@@ design/k_way_sorted_merge_unit.sv @@
// latency: a result word is loaded into the output register at the edge that accepts
//   its item word and is offered from the next cycle on
// throughput: a push, an empty pop or a pop that empties its list leaves the unit ready for
//   the next item word; a pop that leaves its list nonempty stalls input while the refill state reloads the list's head
//   through the element memory's single read port; a stalled result word blocks input
// reset: rst_n is asynchronous active low and empties every list at once
//   (pointers and fill counts go to zero); the element memory is not cleared
module k_way_sorted_merge_unit #(
    parameter int NUM_LISTS   = 8,
    parameter int LIST_DEPTH  = 64,
    parameter int VALUE_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  kwsm_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output kwsm_pkg::result_t result
);

    // widths that follow from the parameters
    localparam int LW        = $clog2(NUM_LISTS);
    localparam int PW        = $clog2(LIST_DEPTH);
    localparam int CW        = $clog2(LIST_DEPTH + 1);
    localparam int AW        = LW + PW;
    localparam int MEM_DEPTH = NUM_LISTS * (2 ** PW);
    localparam int P         = 2 ** LW;

    // element memory: one row of 2**PW slots per list, addressed {list, pointer}
    logic signed [VALUE_WIDTH-1:0] element_mem [MEM_DEPTH];
    logic signed [VALUE_WIDTH-1:0] rdata_reg;

    // per-list fifo control and the cached head of each list
    logic [PW-1:0]                 rp_reg   [NUM_LISTS];
    logic [PW-1:0]                 wp_reg   [NUM_LISTS];
    logic [CW-1:0]                 cnt_reg  [NUM_LISTS];
    logic signed [VALUE_WIDTH-1:0] head_reg [NUM_LISTS];

    kwsm_pkg::state_t state_reg;
    kwsm_pkg::state_t state_next;
    logic [LW-1:0]    refill_list_reg;

    logic              result_valid_reg;
    kwsm_pkg::result_t result_reg;
    kwsm_pkg::result_t result_next;

    // minimum search tree: level 0 holds the heads, the root sits at level LW
    logic                          t_vld [LW+1][P];
    logic [LW-1:0]                 t_idx [LW+1][P];
    logic signed [VALUE_WIDTH-1:0] t_val [LW+1][P];

    logic                          accept;
    logic                          is_push;
    logic                          is_pop;
    logic                          idx_ok;
    logic [LW-1:0]                 idx;
    logic                          push_ok;
    logic signed [VALUE_WIDTH-1:0] push_raw;
    logic [PW-1:0]                 wp_inc;
    logic                          found;
    logic [LW-1:0]                 best;
    logic [PW-1:0]                 rp_inc;
    logic                          refill_needed;
    logic                          rd_en;
    logic [AW-1:0]                 raddr;
    logic [AW-1:0]                 waddr;

    assign accept   = item_valid && !item_stall;
    assign is_push  = (item.func == kwsm_pkg::FUNC_PUSH);
    assign is_pop   = (item.func == kwsm_pkg::FUNC_POP);
    // a push to a list number past the configured count behaves as a push to a full list
    assign idx_ok   = ({29'd0, item.list_index} < 32'(NUM_LISTS));
    assign idx      = LW'(item.list_index);
    assign push_ok  = idx_ok && (cnt_reg[idx] != CW'(LIST_DEPTH));
    assign push_raw = VALUE_WIDTH'(item.value);
    assign wp_inc   = (wp_reg[idx] == PW'(LIST_DEPTH - 1)) ? '0 : wp_reg[idx] + PW'(1);
    assign waddr    = {idx, wp_reg[idx]};

    assign found    = t_vld[LW][0];
    assign best     = t_idx[LW][0];
    assign rp_inc   = (rp_reg[best] == PW'(LIST_DEPTH - 1)) ? '0 : rp_reg[best] + PW'(1);
    // the list still holds elements after this pop, so its new head must be fetched
    assign refill_needed = (cnt_reg[best] != CW'(1));
    assign rd_en    = accept && is_pop && found && refill_needed;
    assign raddr    = {best, rp_inc};

    // pairwise tree; on a tie the left (lower index) side wins
    always_comb
    begin
        for (int l = 0; l <= LW; l++)
        begin
            for (int j = 0; j < P; j++)
            begin
                t_vld[l][j] = 1'b0;
                t_idx[l][j] = '0;
                t_val[l][j] = '0;
            end
        end
        for (int j = 0; j < NUM_LISTS; j++)
        begin
            t_vld[0][j] = (cnt_reg[j] != '0);
            t_idx[0][j] = LW'(j);
            t_val[0][j] = head_reg[j];
        end
        for (int l = 1; l <= LW; l++)
        begin
            for (int j = 0; j < (P >> l); j++)
            begin
                if (t_vld[l-1][2*j+1]
                    && (!t_vld[l-1][2*j] || (t_val[l-1][2*j+1] < t_val[l-1][2*j])))
                begin
                    t_vld[l][j] = 1'b1;
                    t_idx[l][j] = t_idx[l-1][2*j+1];
                    t_val[l][j] = t_val[l-1][2*j+1];
                end
                else
                begin
                    t_vld[l][j] = t_vld[l-1][2*j];
                    t_idx[l][j] = t_idx[l-1][2*j];
                    t_val[l][j] = t_val[l-1][2*j];
                end
            end
        end
    end

    // control: next state, stall and the result word
    always_comb
    begin
        state_next  = state_reg;
        item_stall  = 1'b1;
        result_next = '{status: kwsm_pkg::ST_PUSHED, out_value: '0, source_list: '0};
        case (state_reg)
            kwsm_pkg::S_IDLE:
            begin
                // output register frees up when the current word leaves
                item_stall = result_valid_reg && result_stall;
                if (is_push)
                begin
                    result_next.status = push_ok ? kwsm_pkg::ST_PUSHED : kwsm_pkg::ST_FULL;
                end
                else if (found)
                begin
                    result_next.status      = kwsm_pkg::ST_POPPED;
                    result_next.out_value   = 16'(t_val[LW][0]);
                    result_next.source_list = 3'(best);
                end
                else
                begin
                    result_next.status = kwsm_pkg::ST_EMPTY;
                end
                if (rd_en)
                begin
                    state_next = kwsm_pkg::S_REFILL;
                end
            end
            kwsm_pkg::S_REFILL:
            begin
                state_next = kwsm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = kwsm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kwsm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // element memory: one write port for pushes, one registered read port for refills
    always_ff @(posedge clk)
    begin
        if (accept && is_push && push_ok)
        begin
            element_mem[waddr] <= push_raw;
        end
        if (rd_en)
        begin
            rdata_reg <= element_mem[raddr];
        end
    end

    // fifo pointers and fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_LISTS; j++)
            begin
                rp_reg[j]  <= '0;
                wp_reg[j]  <= '0;
                cnt_reg[j] <= '0;
            end
        end
        else if (accept)
        begin
            if (is_push && push_ok)
            begin
                wp_reg[idx]  <= wp_inc;
                cnt_reg[idx] <= cnt_reg[idx] + CW'(1);
            end
            else if (is_pop && found)
            begin
                rp_reg[best]  <= rp_inc;
                cnt_reg[best] <= cnt_reg[best] - CW'(1);
            end
        end
    end

    // head cache: a push into an empty list loads it directly, a pop that leaves its list nonempty reloads from memory
    always_ff @(posedge clk)
    begin
        if (accept && is_push && push_ok && (cnt_reg[idx] == '0))
        begin
            head_reg[idx] <= push_raw;
        end
        if (state_reg == kwsm_pkg::S_REFILL)
        begin
            head_reg[refill_list_reg] <= rdata_reg;
        end
        if (rd_en)
        begin
            refill_list_reg <= best;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // every accepted item word leaves a result word in the output register
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid_reg)
        else $error("accepted item produced no result word");

    // a head reload is followed directly by the idle state
    a_refill_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kwsm_pkg::S_REFILL) |=> (state_reg == kwsm_pkg::S_IDLE))
        else $error("refill did not return to idle");

    // no item may enter while a head reload is pending
    a_no_accept_in_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kwsm_pkg::S_REFILL) |-> item_stall)
        else $error("item accepted during refill");

    // the list being reloaded still holds elements
    a_refill_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kwsm_pkg::S_REFILL) |-> (cnt_reg[refill_list_reg] != '0))
        else $error("refill of an empty list");

    // a pop that finds a list reports popped (its value, that list's head, is not checked here)
    a_pop_reports_popped: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_pop && found)
            |=> (result_reg.status == kwsm_pkg::ST_POPPED))
        else $error("pop with a nonempty list did not report popped");

endmodule
